@@ hw/rtl/ssm_pkg.sv @@
// ssm_pkg: types, constants and helper functions for the static stability margin unit
// used by static_stability_margin_unit; depends on nothing else

package ssm_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;

  // result width and saturation value
  localparam int unsigned OUT_W   = 17;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // magnitude widths feeding the multipliers
  localparam int unsigned PT_W  = OUT_W;      // point offset magnitude
  localparam int unsigned MID_W = OUT_W + 1;  // doubled midpoint offset magnitude

  // radicand and root of the digit-by-digit square root
  localparam int unsigned RAD_W  = 38;
  localparam int unsigned ROOT_W = 19;

  // root bits resolved per pipeline stage, and number of root stages
  localparam int unsigned SQ_BPS = 3;
  localparam int unsigned SQ_STG = (ROOT_W + SQ_BPS - 1) / SQ_BPS;

  typedef enum logic [1:0] {
    PAIR_STAB_LHM   = 2'd0,
    PAIR_SHANK_LHM  = 2'd1,
    PAIR_SHANK_STAB = 2'd2
  } pair_e;

  typedef struct packed {
    logic [RAD_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_pair_t;

  typedef struct packed {
    sq_pair_t mar;
    sq_pair_t mid;
    logic     mar_sat;
    logic     mid_sat;
    pair_e    pair;
  } sq_stage_t;

  // one restoring square root step for root bit b
  function automatic sq_pair_t sqrt_step(sq_pair_t p, int unsigned b);
    logic [RAD_W-1:0] trial;
    sq_pair_t         r;
    trial = (RAD_W'(p.root) << (b + 1)) + (RAD_W'(1) << (2 * b));
    r = p;
    if (p.rem >= trial) begin
      r.rem  = p.rem - trial;
      r.root = p.root | (ROOT_W'(1) << b);
    end
    return r;
  endfunction

  // saturate a root to the result width
  function automatic logic [OUT_W-1:0] clamp_out(logic [ROOT_W-1:0] r, logic sat);
    logic [OUT_W-1:0] o;
    if (sat || ((r >> OUT_W) != '0)) begin
      o = OUT_MAX;
    end else begin
      o = r[OUT_W-1:0];
    end
    return o;
  endfunction

endpackage

@@ hw/rtl/static_stability_margin_unit.sv @@
// static_stability_margin_unit: picks a contact pair and computes the stability margin
// and the midpoint distance; depends on ssm_pkg
//
//  channel | signals                                     | dir
//  in      | in_valid_i, in_stall_o, contacts, coords    | in
//  out     | out_valid_o, out_stall_i, margin, mid, pair | out
//
// one word enters per cycle when the output is not stalled
// stages: select and offsets, squares, sums and min pick, 7 root stages, saturate
// each stage holds when it is full and the stage after it holds, so bubbles fill up
// words with no pair in contact are accepted and drop out at the first stage
// reset clears the valid bits only

module static_stability_margin_unit #(
  parameter int unsigned COORD_WIDTH = ssm_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          stab_contact_i,
  input  logic                          lhm_contact_i,
  input  logic                          shank_contact_i,
  input  logic signed [COORD_WIDTH-1:0] com_x_i,
  input  logic signed [COORD_WIDTH-1:0] com_y_i,
  input  logic signed [COORD_WIDTH-1:0] shank_x_i,
  input  logic signed [COORD_WIDTH-1:0] shank_y_i,
  input  logic signed [COORD_WIDTH-1:0] lhm_x_i,
  input  logic signed [COORD_WIDTH-1:0] lhm_y_i,
  input  logic signed [COORD_WIDTH-1:0] stab_x_i,
  input  logic signed [COORD_WIDTH-1:0] stab_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ssm_pkg::OUT_W-1:0]     margin_o,
  output logic [ssm_pkg::OUT_W-1:0]     midpoint_distance_o,
  output logic [1:0]                    pair_used_o
);

  localparam int unsigned MW     = COORD_WIDTH + 2;
  localparam int unsigned EW     = (MW > ssm_pkg::MID_W) ? MW : ssm_pkg::MID_W;
  localparam int unsigned SQ_STG = ssm_pkg::SQ_STG;
  localparam int unsigned NSTG   = 3 + SQ_STG + 1;
  localparam int unsigned PSQ_W  = 2 * ssm_pkg::PT_W;
  localparam int unsigned MSQ_W  = 2 * ssm_pkg::MID_W;

  // valid bits and stage load enables
  logic [NSTG-1:0] v_q, v_d, en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  // ---------------------------------------------------------------- stage 0: select, offsets
  logic signed [EW-1:0] cx, cy, ax, ay, bx, by, m1x, m1y, m2x, m2y;
  logic signed [EW-1:0] dax, day, dbx, dby, dmx, dmy;
  logic [EW-1:0]        aax, aay, abx, aby, amx, amy;
  logic                 pair_ok;
  ssm_pkg::pair_e       pair_sel;

  always_comb begin
    cx  = {{(EW-COORD_WIDTH){com_x_i[COORD_WIDTH-1]}}, com_x_i};
    cy  = {{(EW-COORD_WIDTH){com_y_i[COORD_WIDTH-1]}}, com_y_i};
    m1x = {{(EW-COORD_WIDTH){shank_x_i[COORD_WIDTH-1]}}, shank_x_i};
    m1y = {{(EW-COORD_WIDTH){shank_y_i[COORD_WIDTH-1]}}, shank_y_i};
    m2x = {{(EW-COORD_WIDTH){lhm_x_i[COORD_WIDTH-1]}}, lhm_x_i};
    m2y = {{(EW-COORD_WIDTH){lhm_y_i[COORD_WIDTH-1]}}, lhm_y_i};
    ax  = {{(EW-COORD_WIDTH){stab_x_i[COORD_WIDTH-1]}}, stab_x_i};
    ay  = {{(EW-COORD_WIDTH){stab_y_i[COORD_WIDTH-1]}}, stab_y_i};
    bx  = m2x;
    by  = m2y;
    pair_ok  = 1'b1;
    pair_sel = ssm_pkg::PAIR_STAB_LHM;
    if (stab_contact_i && lhm_contact_i) begin
      pair_sel = ssm_pkg::PAIR_STAB_LHM;
    end else if (shank_contact_i && lhm_contact_i) begin
      pair_sel = ssm_pkg::PAIR_SHANK_LHM;
      ax = m1x;
      ay = m1y;
    end else if (shank_contact_i && stab_contact_i) begin
      // midpoint now runs to shank and stabilizer
      pair_sel = ssm_pkg::PAIR_SHANK_STAB;
      bx  = ax;
      by  = ay;
      m2x = ax;
      m2y = ay;
      ax  = m1x;
      ay  = m1y;
    end else begin
      pair_ok = 1'b0;
    end
    dax = ax - cx;
    day = ay - cy;
    dbx = bx - cx;
    dby = by - cy;
    dmx = (m1x + m2x) - (cx <<< 1);
    dmy = (m1y + m2y) - (cy <<< 1);
    aax = dax[EW-1] ? EW'(-dax) : EW'(dax);
    aay = day[EW-1] ? EW'(-day) : EW'(day);
    abx = dbx[EW-1] ? EW'(-dbx) : EW'(dbx);
    aby = dby[EW-1] ? EW'(-dby) : EW'(dby);
    amx = dmx[EW-1] ? EW'(-dmx) : EW'(dmx);
    amy = dmy[EW-1] ? EW'(-dmy) : EW'(dmy);
  end

  logic [ssm_pkg::PT_W-1:0]  s0_ax_q, s0_ay_q, s0_bx_q, s0_by_q;
  logic [ssm_pkg::MID_W-1:0] s0_mx_q, s0_my_q;
  logic                      s0_sa_q, s0_sb_q, s0_sm_q;
  ssm_pkg::pair_e            s0_pair_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_ax_q   <= aax[ssm_pkg::PT_W-1:0];
      s0_ay_q   <= aay[ssm_pkg::PT_W-1:0];
      s0_bx_q   <= abx[ssm_pkg::PT_W-1:0];
      s0_by_q   <= aby[ssm_pkg::PT_W-1:0];
      s0_mx_q   <= amx[ssm_pkg::MID_W-1:0];
      s0_my_q   <= amy[ssm_pkg::MID_W-1:0];
      s0_sa_q   <= ((aax >> ssm_pkg::PT_W) != '0) || ((aay >> ssm_pkg::PT_W) != '0);
      s0_sb_q   <= ((abx >> ssm_pkg::PT_W) != '0) || ((aby >> ssm_pkg::PT_W) != '0);
      s0_sm_q   <= ((amx >> ssm_pkg::MID_W) != '0) || ((amy >> ssm_pkg::MID_W) != '0);
      s0_pair_q <= pair_sel;
    end
  end

  // ---------------------------------------------------------------- stage 1: squares
  logic [PSQ_W-1:0] s1_ax_q, s1_ay_q, s1_bx_q, s1_by_q;
  logic [MSQ_W-1:0] s1_mx_q, s1_my_q;
  logic             s1_sa_q, s1_sb_q, s1_sm_q;
  ssm_pkg::pair_e   s1_pair_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_ax_q   <= PSQ_W'(s0_ax_q) * PSQ_W'(s0_ax_q);
      s1_ay_q   <= PSQ_W'(s0_ay_q) * PSQ_W'(s0_ay_q);
      s1_bx_q   <= PSQ_W'(s0_bx_q) * PSQ_W'(s0_bx_q);
      s1_by_q   <= PSQ_W'(s0_by_q) * PSQ_W'(s0_by_q);
      s1_mx_q   <= MSQ_W'(s0_mx_q) * MSQ_W'(s0_mx_q);
      s1_my_q   <= MSQ_W'(s0_my_q) * MSQ_W'(s0_my_q);
      s1_sa_q   <= s0_sa_q;
      s1_sb_q   <= s0_sb_q;
      s1_sm_q   <= s0_sm_q;
      s1_pair_q <= s0_pair_q;
    end
  end

  // ---------------------------------------------------------------- stage 2: sums, min pick
  // root is monotone, so the smaller radicand gives the smaller distance
  logic [PSQ_W:0]   sum_a, sum_b;
  logic [MSQ_W:0]   sum_m;
  logic [PSQ_W:0]   mar_rad;
  logic             mar_sat;

  always_comb begin
    sum_a = (PSQ_W+1)'(s1_ax_q) + (PSQ_W+1)'(s1_ay_q);
    sum_b = (PSQ_W+1)'(s1_bx_q) + (PSQ_W+1)'(s1_by_q);
    sum_m = (MSQ_W+1)'(s1_mx_q) + (MSQ_W+1)'(s1_my_q);
    mar_sat = s1_sa_q && s1_sb_q;
    if (s1_sa_q) begin
      mar_rad = sum_b;
    end else if (s1_sb_q) begin
      mar_rad = sum_a;
    end else begin
      mar_rad = (sum_a < sum_b) ? sum_a : sum_b;
    end
  end

  ssm_pkg::sq_stage_t s2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_q.mar.rem  <= ssm_pkg::RAD_W'(mar_rad);
      s2_q.mar.root <= '0;
      s2_q.mid.rem  <= ssm_pkg::RAD_W'(sum_m);
      s2_q.mid.root <= '0;
      s2_q.mar_sat  <= mar_sat;
      s2_q.mid_sat  <= s1_sm_q;
      s2_q.pair     <= s1_pair_q;
    end
  end

  // ---------------------------------------------------------------- root stages
  ssm_pkg::sq_stage_t sq_in [SQ_STG];
  ssm_pkg::sq_stage_t sq_nx [SQ_STG];
  ssm_pkg::sq_stage_t sq_q  [SQ_STG];

  for (genvar s = 0; s < SQ_STG; s++) begin : g_root
    if (s == 0) begin : g_first
      assign sq_in[s] = s2_q;
    end else begin : g_next
      assign sq_in[s] = sq_q[s-1];
    end

    always_comb begin
      int b;
      sq_nx[s] = sq_in[s];
      for (int j = 0; j < ssm_pkg::SQ_BPS; j++) begin
        b = ssm_pkg::ROOT_W - 1 - s * ssm_pkg::SQ_BPS - j;
        if (b >= 0) begin
          sq_nx[s].mar = ssm_pkg::sqrt_step(sq_nx[s].mar, b);
          sq_nx[s].mid = ssm_pkg::sqrt_step(sq_nx[s].mid, b);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[3+s]) begin
        sq_q[s] <= sq_nx[s];
      end
    end
  end

  // ---------------------------------------------------------------- output stage
  logic [ssm_pkg::OUT_W-1:0] margin_q, mid_q;
  ssm_pkg::pair_e            pair_q;

  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      margin_q <= ssm_pkg::clamp_out(sq_q[SQ_STG-1].mar.root, sq_q[SQ_STG-1].mar_sat);
      // midpoint offsets were doubled, so halve the root
      mid_q    <= ssm_pkg::clamp_out(sq_q[SQ_STG-1].mid.root >> 1, sq_q[SQ_STG-1].mid_sat);
      pair_q   <= sq_q[SQ_STG-1].pair;
    end
  end

  // ---------------------------------------------------------------- valid bits
  always_comb begin
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i && pair_ok;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign out_valid_o         = v_q[NSTG-1];
  assign margin_o            = margin_q;
  assign midpoint_distance_o = mid_q;
  assign pair_used_o         = pair_q;

  // ---------------------------------------------------------------- assertions
  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q) && out_stall_i)
    else $error("input stalled while the pipeline has room");

  a_no_lost_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(out_valid_o && !out_stall_i) |-> $countones(v_q) >= $past($countones(v_q)))
    else $error("word dropped inside the pipeline");

  a_pair_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pair_used_o == ssm_pkg::PAIR_STAB_LHM) ||
                    (pair_used_o == ssm_pkg::PAIR_SHANK_LHM) ||
                    (pair_used_o == ssm_pkg::PAIR_SHANK_STAB))
    else $error("bad pair code on output");

endmodule
